// ----- sv/scl_pkg.sv -----
// shared types, constants and lookup functions of the source code lexer
`default_nettype none
package scl_pkg;

   // lexer modes, one-hot
   typedef enum logic [5:0] {
      MODE_IDLE = 6'b000001,
      MODE_NAME = 6'b000010,
      MODE_NUM  = 6'b000100,
      MODE_STR  = 6'b001000,
      MODE_SKIP = 6'b010000,
      MODE_ERR  = 6'b100000
   } mode_type;

   // number kinds, also their token kinds
   localparam logic [2:0] NK_NUM = 3'd0;
   localparam logic [2:0] NK_BIN = 3'd1;
   localparam logic [2:0] NK_OCT = 3'd2;
   localparam logic [2:0] NK_HEX = 3'd3;
   localparam logic [2:0] NK_FLT = 3'd4;

   // token kinds used by name
   localparam logic [6:0] TK_NONE      = 7'd0;
   localparam logic [6:0] TK_STR       = 7'd5;
   localparam logic [6:0] TK_IDEN      = 7'd6;
   localparam logic [6:0] TK_STRUCT    = 7'd7;
   localparam logic [6:0] TK_RETURN    = 7'd8;
   localparam logic [6:0] TK_CONTINUE  = 7'd9;
   localparam logic [6:0] TK_BREAK     = 7'd10;
   localparam logic [6:0] TK_EXTERN    = 7'd11;
   localparam logic [6:0] TK_DOLLAR    = 7'd56;
   localparam logic [6:0] TK_TWODOLLAR = 7'd57;
   localparam logic [7:0] KIND_NONE    = 8'hFF;

   // error codes
   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_CLOSE     = 4'd1;
   localparam logic [3:0] ERR_BIN_DIGIT = 4'd2;
   localparam logic [3:0] ERR_OCT_DIGIT = 4'd3;
   localparam logic [3:0] ERR_OCT_MARK  = 4'd4;
   localparam logic [3:0] ERR_HEX_MARK  = 4'd5;
   localparam logic [3:0] ERR_HEX_ALPHA = 4'd6;
   localparam logic [3:0] ERR_DOT       = 4'd7;
   localparam logic [3:0] ERR_OPEN_STR  = 4'd8;
   localparam logic [3:0] ERR_UNKNOWN   = 4'd9;

   // pending shift operators
   localparam logic [7:0] PEND_NONE = 8'd0;
   localparam logic [7:0] PEND_SHL  = 8'd1;
   localparam logic [7:0] PEND_SHR  = 8'd2;

   localparam int          KEYWORD_CHARS = 8;
   localparam logic [11:0] LEN_TOP       = 12'hFFF;
   localparam int          MAX_RES       = 4;

   // keywords packed first character in the low byte
   localparam logic [63:0] KW_STRUCT   = 64'h0000_7463_7572_7473;
   localparam logic [63:0] KW_RETURN   = 64'h0000_6E72_7574_6572;
   localparam logic [63:0] KW_CONTINUE = 64'h6575_6E69_746E_6F63;
   localparam logic [63:0] KW_BREAK    = 64'h0000_006B_6165_7262;
   localparam logic [63:0] KW_EXTERN   = 64'h0000_6E72_6574_7865;

   typedef struct packed {
      logic [6:0]  kind;
      logic [15:0] line;
      logic [11:0] col;
      logic [11:0] len;
      logic        text;
      logic [3:0]  err;
      logic        last;
   } res_type;

   // all results of one byte
   typedef struct packed {
      logic [2:0]            count;
      res_type [MAX_RES-1:0] res;
   } bundle_type;

   // kind of a lone operator
   function automatic logic [6:0] single_kind(input logic [7:0] p);
      case (p)
         "*": return 7'd15;
         "/": return 7'd16;
         "+": return 7'd13;
         "-": return 7'd14;
         "%": return 7'd17;
         "&": return 7'd35;
         "|": return 7'd36;
         "~": return 7'd37;
         "=": return 7'd12;
         "<": return 7'd30;
         ">": return 7'd31;
         "!": return 7'd28;
         "^": return 7'd38;
         ".": return 7'd51;
         "$": return 7'd56;
         PEND_SHL: return 7'd44;
         PEND_SHR: return 7'd45;
         default: return TK_NONE;
      endcase
   endfunction

   // kind of a two-character operator, KIND_NONE if no pair
   function automatic logic [7:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
      if (c == "=") begin
         case (p)
            "*": return 8'd20;
            "/": return 8'd21;
            "+": return 8'd18;
            "-": return 8'd19;
            "%": return 8'd22;
            "&": return 8'd39;
            "|": return 8'd40;
            "~": return 8'd41;
            "=": return 8'd29;
            "<": return 8'd32;
            ">": return 8'd33;
            "!": return 8'd34;
            "^": return 8'd42;
            PEND_SHL: return 8'd46;
            PEND_SHR: return 8'd47;
            default: return KIND_NONE;
         endcase
      end
      if (p == "*" && c == "*") return 8'd25;
      if (p == "+" && c == "+") return 8'd23;
      if (p == "-" && c == "-") return 8'd24;
      if (p == "-" && c == ">") return 8'd60;
      if (p == "&" && c == "&") return 8'd26;
      if (p == "|" && c == "|") return 8'd27;
      if (p == "<" && c == "-") return 8'd59;
      if (p == "." && c == ".") return 8'd52;
      if (p == "$" && c == "$") return 8'd57;
      return KIND_NONE;
   endfunction

   // kind of a single-character punctuation token, KIND_NONE otherwise
   function automatic logic [7:0] punct_kind(input logic [7:0] c);
      case (c)
         "?": return 8'd43;
         ",": return 8'd53;
         ":": return 8'd54;
         ";": return 8'd55;
         "@": return 8'd58;
         "(": return 8'd61;
         ")": return 8'd62;
         "{": return 8'd63;
         "}": return 8'd64;
         "[": return 8'd65;
         "]": return 8'd66;
         default: return KIND_NONE;
      endcase
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_numchar(input logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") ||
             c == "o" || c == "O" || c == "x" || c == "X" || c == ".";
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return c == "*" || c == "/" || c == "+" || c == "-" || c == "%" || c == "&" ||
             c == "|" || c == "~" || c == "=" || c == "<" || c == ">" || c == "!" ||
             c == "^" || c == "." || c == "$";
   endfunction

endpackage
`default_nettype wire

// ----- sv/scl_req_if.sv -----
// source byte channel
`default_nettype none
interface scl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       line_end;
   logic       source_end;

   modport source (output valid, char_byte, line_end, source_end, input ready);
   modport sink (input valid, char_byte, line_end, source_end, output ready);
endinterface
`default_nettype wire

// ----- sv/scl_rsp_if.sv -----
// token result channel
`default_nettype none
interface scl_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  token_kind;
   logic [15:0] line_number;
   logic [11:0] column_after;
   logic [11:0] token_length;
   logic        has_text;
   logic [3:0]  error_code;
   logic        last_of_run;

   modport source (output valid, token_kind, line_number, column_after, token_length,
                   has_text, error_code, last_of_run, input ready);
   modport sink (input valid, token_kind, line_number, column_after, token_length,
                 has_text, error_code, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- sv/scl_front.sv -----
// front end: one byte a cycle unless full; updates the mode state, bundles its tokens
`default_nettype none
module scl_front #(
   parameter int COLUMN_BITS = 12,
   parameter int LINE_BITS   = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   scl_req_if.sink                req_ch,
   output logic                   push,
   output scl_pkg::bundle_type    push_word,
   input  wire                    full
);
   import scl_pkg::*;

   localparam logic [COLUMN_BITS-1:0] COL_TOP  = {COLUMN_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0]   LINE_TOP = {LINE_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0]   LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

   mode_type               mode_ff, mode_in;
   logic                   bc_ff, bc_in;
   logic [7:0]             pend_ff, pend_in;
   logic [2:0]             nk_ff, nk_in;
   logic                   dot_ff, dot_in;
   logic                   qd_ff, qd_in;
   logic [7:0]             prev_ff, prev_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [63:0]            kw_ff, kw_in;
   logic                   any_ff, any_in;
   logic                   wdd_ff, wdd_in;
   logic                   lhc_ff, lhc_in;
   logic [11:0]            len_ff, len_in;
   bundle_type             word;
   logic                   accept;

   function automatic logic [COLUMN_BITS-1:0] col_next(input logic [COLUMN_BITS-1:0] v);
      return (v == COL_TOP) ? v : v + 1'b1;
   endfunction

   // append one result to the bundle
   function automatic void add_res(inout bundle_type b, inout logic any_tok,
                                   input logic [6:0] k, input logic [15:0] l,
                                   input logic [11:0] cl, input logic [11:0] n,
                                   input logic t, input logic [3:0] e);
      if (b.count < 3'(MAX_RES)) begin
         b.res[b.count[1:0]] = '{kind: k, line: l, col: cl, len: n, text: t, err: e,
                                 last: 1'b0};
         b.count = b.count + 3'd1;
         if (e == ERR_NONE) any_tok = 1'b1;
      end
   endfunction

   function automatic logic [6:0] name_kind(input logic [11:0] n, input logic [63:0] kb);
      if (n > 12'(KEYWORD_CHARS)) return TK_IDEN;
      if (kb == KW_STRUCT) return TK_STRUCT;
      if (kb == KW_RETURN) return TK_RETURN;
      if (kb == KW_CONTINUE) return TK_CONTINUE;
      if (kb == KW_BREAK) return TK_BREAK;
      if (kb == KW_EXTERN) return TK_EXTERN;
      return TK_IDEN;
   endfunction

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !full;

   // next state and results of the byte on the channel
   always_comb begin
      logic [7:0]             c;
      logic                   le, se, cont, used, ok, second;
      logic [COLUMN_BITS-1:0] after;
      logic [15:0]            ln16;
      logic [7:0]             pk, p;
      logic [6:0]             nm;
      mode_in = mode_ff;  bc_in = bc_ff;    pend_in = pend_ff; nk_in = nk_ff;
      dot_in  = dot_ff;   qd_in = qd_ff;    prev_in = prev_ff; col_in = col_ff;
      line_in = line_ff;  kw_in = kw_ff;    any_in = any_ff;   wdd_in = wdd_ff;
      lhc_in  = lhc_ff;   len_in = len_ff;
      word = '0;
      c  = req_ch.char_byte;
      le = req_ch.line_end;
      se = req_ch.source_end;
      cont = 1'b0; used = 1'b0; ok = 1'b1; second = 1'b0;
      after = '0; pk = '0; p = '0; nm = '0;
      ln16 = 16'(line_ff);

      if (mode_in != MODE_ERR) begin
         // first byte of a line
         if (col_in == '0) begin
            prev_in = 8'd0;
            lhc_in = (c != 8'h0A);
            if (!lhc_in) mode_in = MODE_SKIP;
         end
         col_in = col_next(col_in);

         // continue an open token
         cont = 1'b0;
         if (mode_in == MODE_NAME) begin
            if (is_alpha(c) || is_digit(c) || c == "_") begin
               if (len_in < 12'(KEYWORD_CHARS)) kw_in[8*len_in[2:0] +: 8] = c;
               if (len_in != LEN_TOP) len_in = len_in + 12'd1;
            end else begin
               nm = name_kind(len_in, kw_in);
               add_res(word, any_in, nm, ln16, 12'(col_in), len_in, 1'b1, ERR_NONE);
               mode_in = MODE_IDLE;
               cont = 1'b1;
            end
         end else if (mode_in == MODE_NUM) begin
            if (is_numchar(c)) begin
               second = (len_in == 12'd1);
               ok = 1'b1;
               if (c >= "2" && c <= "9") begin
                  if (nk_in == NK_BIN) begin
                     add_res(word, any_in, TK_NONE, ln16, 12'(col_in), 12'd0, 1'b0,
                             ERR_BIN_DIGIT);
                     ok = 1'b0;
                  end else if (c >= "8" && nk_in == NK_OCT) begin
                     add_res(word, any_in, TK_NONE, ln16, 12'(col_in), 12'd0, 1'b0,
                             ERR_OCT_DIGIT);
                     ok = 1'b0;
                  end
               end else if (c == "o" || c == "O") begin
                  if (!second) begin
                     add_res(word, any_in, TK_NONE, ln16, 12'(col_in), 12'd0, 1'b0,
                             ERR_OCT_MARK);
                     ok = 1'b0;
                  end else nk_in = NK_OCT;
               end else if (c == "x" || c == "X") begin
                  if (!second) begin
                     add_res(word, any_in, TK_NONE, ln16, 12'(col_in), 12'd0, 1'b0,
                             ERR_HEX_MARK);
                     ok = 1'b0;
                  end else nk_in = NK_HEX;
               end else if (c == ".") begin
                  if (dot_in) begin
                     add_res(word, any_in, TK_NONE, ln16, 12'(col_in), 12'd0, 1'b0,
                             ERR_DOT);
                     ok = 1'b0;
                  end else begin
                     dot_in = 1'b1;
                     nk_in = NK_FLT;
                  end
               end else if (!is_digit(c)) begin
                  if (second && (c == "a" || c == "A" || c == "b" || c == "B"))
                     nk_in = NK_BIN;
                  else if (nk_in != NK_HEX) begin
                     add_res(word, any_in, TK_NONE, ln16, 12'(col_in), 12'd0, 1'b0,
                             ERR_HEX_ALPHA);
                     ok = 1'b0;
                  end
               end
               if (!ok) begin
                  mode_in = MODE_ERR;
                  pend_in = PEND_NONE;
               end else if (len_in != LEN_TOP) len_in = len_in + 12'd1;
            end else begin
               add_res(word, any_in, 7'(nk_in), ln16, 12'(col_in), len_in, 1'b1, ERR_NONE);
               mode_in = MODE_IDLE;
               cont = 1'b1;
            end
         end else if (mode_in == MODE_STR) begin
            if (c == (qd_in ? 8'h22 : 8'h27) && prev_in != "\\") begin
               add_res(word, any_in, TK_STR, ln16, 12'(col_next(col_in)), len_in, 1'b1,
                       ERR_NONE);
               mode_in = MODE_IDLE;
            end else if (len_in != LEN_TOP) len_in = len_in + 12'd1;
         end else if (mode_in == MODE_IDLE) begin
            cont = 1'b1;
         end

         // resolve a pending operator against this byte
         used = 1'b0;
         if (cont && pend_in != PEND_NONE) begin
            p = pend_in;
            pend_in = PEND_NONE;
            used = 1'b1;
            if (bc_in) begin
               if (c == "/") bc_in = 1'b0;
               else used = 1'b0;
            end else if (p == "*" && c == "/") begin
               add_res(word, any_in, TK_NONE, ln16, 12'(col_in - 1'b1), 12'd0, 1'b0,
                       ERR_CLOSE);
               mode_in = MODE_ERR;
            end else if (p == "/" && c == "*") begin
               bc_in = 1'b1;
            end else if (p == "<" && c == "<") begin
               pend_in = PEND_SHL;
            end else if (p == ">" && c == ">") begin
               pend_in = PEND_SHR;
            end else begin
               pk = pair_kind(p, c);
               if (pk != KIND_NONE) begin
                  add_res(word, any_in, pk[6:0], ln16, 12'(col_next(col_in)), 12'd0, 1'b0,
                          ERR_NONE);
               end else begin
                  add_res(word, any_in, single_kind(p), ln16, 12'(col_in), 12'd0, 1'b0,
                          ERR_NONE);
                  used = 1'b0;
               end
            end
         end

         // start a new token
         if (cont && !used && mode_in != MODE_ERR && !is_space(c)) begin
            pk = punct_kind(c);
            if (bc_in) begin
               if (c == "*") pend_in = c;
            end else if (is_alpha(c) || c == "_") begin
               mode_in = MODE_NAME;
               len_in = 12'd1;
               kw_in = {56'd0, c};
            end else if (is_digit(c)) begin
               mode_in = MODE_NUM;
               len_in = 12'd1;
               nk_in = NK_NUM;
               dot_in = 1'b0;
            end else if (is_operator(c)) begin
               pend_in = c;
            end else if (c == "#") begin
               mode_in = MODE_SKIP;
            end else if (c == 8'h22 || c == 8'h27) begin
               mode_in = MODE_STR;
               qd_in = (c == 8'h22);
               len_in = 12'd0;
            end else if (pk != KIND_NONE) begin
               add_res(word, any_in, pk[6:0], ln16, 12'(col_next(col_in)), 12'd0, 1'b0,
                       ERR_NONE);
            end else begin
               add_res(word, any_in, TK_NONE, ln16, 12'(col_in), 12'd0, 1'b0, ERR_UNKNOWN);
               mode_in = MODE_ERR;
               pend_in = PEND_NONE;
            end
         end

         // close the line
         if (le || se) begin
            after = col_next(col_in);
            if (mode_in == MODE_NAME) begin
               nm = name_kind(len_in, kw_in);
               add_res(word, any_in, nm, ln16, 12'(after), len_in, 1'b1, ERR_NONE);
            end else if (mode_in == MODE_NUM) begin
               add_res(word, any_in, 7'(nk_in), ln16, 12'(after), len_in, 1'b1, ERR_NONE);
            end else if (mode_in == MODE_STR) begin
               add_res(word, any_in, TK_NONE, ln16, 12'(after), 12'd0, 1'b0, ERR_OPEN_STR);
               mode_in = MODE_ERR;
            end
            if (mode_in != MODE_ERR) begin
               if (pend_in != PEND_NONE && !bc_in)
                  add_res(word, any_in, single_kind(pend_in), ln16, 12'(after), 12'd0, 1'b0,
                          ERR_NONE);
               if (lhc_in) begin
                  if (prev_in == "$") wdd_in = 1'b0;
                  else add_res(word, any_in, TK_DOLLAR, 16'd0, 12'd0, 12'd0, 1'b0, ERR_NONE);
               end
               mode_in = MODE_IDLE;
            end
            if (line_in != LINE_TOP) line_in = line_in + 1'b1;
            pend_in = PEND_NONE;
            col_in = '0;
            prev_in = 8'd0;
            lhc_in = 1'b0;
         end else begin
            prev_in = c;
         end
      end

      // end of source: closing token and full reset
      if (se) begin
         if (mode_in != MODE_ERR && any_in && wdd_in)
            add_res(word, any_in, TK_TWODOLLAR, 16'd0, 12'd0, 12'd0, 1'b0, ERR_NONE);
         mode_in = MODE_IDLE; bc_in = 1'b0;  pend_in = PEND_NONE; nk_in = NK_NUM;
         dot_in = 1'b0;       qd_in = 1'b0;  prev_in = 8'd0;      col_in = '0;
         line_in = LINE_ONE;  kw_in = '0;    any_in = 1'b0;       wdd_in = 1'b1;
         lhc_in = 1'b0;       len_in = 12'd0;
      end

      // mark the final result of the byte
      if (word.count != 3'd0) word.res[2'(word.count - 3'd1)].last = 1'b1;
   end

   assign push = accept && (word.count != 3'd0);
   assign push_word = word;

   // lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE; bc_ff <= 1'b0;  pend_ff <= PEND_NONE; nk_ff <= NK_NUM;
         dot_ff <= 1'b0;       qd_ff <= 1'b0;  prev_ff <= 8'd0;      col_ff <= '0;
         line_ff <= LINE_ONE;  kw_ff <= '0;    any_ff <= 1'b0;       wdd_ff <= 1'b1;
         lhc_ff <= 1'b0;       len_ff <= 12'd0;
      end else if (accept) begin
         mode_ff <= mode_in;   bc_ff <= bc_in; pend_ff <= pend_in;   nk_ff <= nk_in;
         dot_ff <= dot_in;     qd_ff <= qd_in; prev_ff <= prev_in;   col_ff <= col_in;
         line_ff <= line_in;   kw_ff <= kw_in; any_ff <= any_in;     wdd_ff <= wdd_in;
         lhc_ff <= lhc_in;     len_ff <= len_in;
      end
   end

   // a pushed bundle carries one to four results, the last one marked
   assert property (@(posedge clock) disable iff (reset)
      push |-> (push_word.count != 3'd0 && push_word.count <= 3'(MAX_RES) &&
                push_word.res[2'(push_word.count - 3'd1)].last))
      else $error("bundle with bad result count");

endmodule
`default_nettype wire

// ----- sv/scl_queue.sv -----
// two-entry queue of result bundles between front and back
`default_nettype none
module scl_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  scl_pkg::bundle_type push_word,
   output logic                full,
   input  wire                 pop,
   output logic                valid,
   output scl_pkg::bundle_type rd_word
);
   import scl_pkg::*;

   bundle_type       entry_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign rd_word = entry_ff[rd_ff];

   // pointers and fill count
   always_comb begin
      wr_in = push ? !wr_ff : wr_ff;
      rd_in = pop ? !rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   // bundle storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_word;
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && !valid))
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("fill count lost a push");

endmodule
`default_nettype wire

// ----- sv/scl_back.sv -----
// lexer back end: sends the results of each bundle one word a cycle while rsp_ch is ready
`default_nettype none
module scl_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 q_valid,
   input  scl_pkg::bundle_type q_word,
   output logic                pop,
   scl_rsp_if.source           rsp_ch
);
   import scl_pkg::*;

   logic       cur_v_ff, cur_v_in;
   bundle_type cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       fire, last_idx, load;
   res_type    r;

   assign fire = cur_v_ff && rsp_ch.ready;
   assign last_idx = ({1'b0, idx_ff} == cur_ff.count - 3'd1);
   assign load = !cur_v_ff || (fire && last_idx);
   assign pop = load && q_valid;

   // bundle hold and result index
   always_comb begin
      cur_v_in = load ? q_valid : cur_v_ff;
      cur_in = pop ? q_word : cur_ff;
      if (load) idx_in = 2'd0;
      else if (fire) idx_in = idx_ff + 2'd1;
      else idx_in = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_v_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         cur_v_ff <= cur_v_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // result word
   assign r = cur_ff.res[idx_ff];
   assign rsp_ch.valid = cur_v_ff;
   assign rsp_ch.token_kind = r.kind;
   assign rsp_ch.line_number = r.line;
   assign rsp_ch.column_after = r.col;
   assign rsp_ch.token_length = r.len;
   assign rsp_ch.has_text = r.text;
   assign rsp_ch.error_code = r.err;
   assign rsp_ch.last_of_run = r.last;

   assert property (@(posedge clock) disable iff (reset)
      cur_v_ff |-> ({1'b0, idx_ff} < cur_ff.count))
      else $error("result index past bundle count");

endmodule
`default_nettype wire

// ----- sv/source_code_lexer_top.sv -----
// top level of the streaming source code lexer
//
// req_ch carries one source byte per word with line_end and source_end marks;
// rsp_ch carries token words: kind, line, column after, length, text flag,
// error code and a last_of_run mark on the final token of each byte.
// The front lexer state is registered when a byte is taken, so bytes stream at
// one per cycle while the queue is not full. Bytes that yield tokens pass their
// tokens as one bundle through a two-entry queue; the back end sends them one
// word a cycle while rsp_ch is ready, so output rate is set by the token count.
// The first token of a byte passes the queue entry, then the output register,
// before it appears on rsp_ch.
// When rsp_ch stalls, the queue fills and req_ch.ready drops once both
// entries are held; no token is lost. Reset empties the queue and output
// register and sets the lexer to idle, line 1, column 0, no token seen.
// After an error, bytes are taken and dropped until the source end mark.
`default_nettype none
module source_code_lexer_top #(
   parameter int COLUMN_BITS = 12,
   parameter int LINE_BITS   = 16
) (
   input  wire        clock,
   input  wire        reset,
   scl_req_if.sink    req_ch,
   scl_rsp_if.source  rsp_ch
);
   import scl_pkg::*;

   logic       push, full, pop, q_valid;
   bundle_type push_word, q_word;

   scl_front #(
      .COLUMN_BITS(COLUMN_BITS),
      .LINE_BITS(LINE_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .push(push),
      .push_word(push_word),
      .full(full)
   );

   scl_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_word(push_word),
      .full(full),
      .pop(pop),
      .valid(q_valid),
      .rd_word(q_word)
   );

   scl_back u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_word(q_word),
      .pop(pop),
      .rsp_ch(rsp_ch)
   );

endmodule
`default_nettype wire
